FILE: src/mrfr_pkg.sv
package mrfr_pkg;

   localparam int MAX_FRAME_BYTES = 20;
   localparam int STORE_DEPTH     = MAX_FRAME_BYTES + 1;
   localparam int IDX_W           = $clog2(STORE_DEPTH);
   localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 2);
   localparam int LEN_W           = 9;

   localparam logic [7:0] START_BYTE    = 8'h3E;
   localparam logic [7:0] CMD_ANGLE     = 8'h92;
   localparam logic [7:0] CMD_STATUS_1  = 8'h9C;
   localparam logic [7:0] CMD_STATUS_2  = 8'hA1;
   localparam logic [7:0] CMD_STATUS_3  = 8'hA2;
   localparam logic [7:0] CMD_STATUS_4  = 8'hA4;

   localparam logic KIND_ANGLE  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // byte positions within a frame
   localparam int POS_START = 0;
   localparam int POS_CMD   = 1;
   localparam int POS_ID    = 2;
   localparam int POS_LEN   = 3;
   localparam int POS_HSUM  = 4;
   localparam int POS_DATA  = 5;

   localparam int FRAME_LEN_EMPTY = 5;
   localparam int FRAME_OVERHEAD  = 6;

   typedef struct packed {
      logic               reply_kind;
      logic [7:0]         command_code;
      logic [7:0]         temperature;
      logic signed [15:0] current_raw;
      logic signed [15:0] speed_raw;
      logic signed [63:0] angle_raw;
   } reply_type;

   typedef struct packed {
      logic      emit;
      reply_type reply;
   } deframe_out_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } byte_item_type;

endpackage

FILE: src/mrfr_in_stage.sv
module mrfr_in_stage import mrfr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [7:0]    req_rx_byte,
   output logic          req_ready,
   input  logic          out_free,
   output byte_item_type item
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       step;

   assign step      = valid_ff && out_free;
   assign req_ready = !valid_ff || step;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         byte_in  = req_rx_byte;
      end else if (step) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign item.valid   = step;
   assign item.rx_byte = byte_ff;

endmodule

FILE: src/mrfr_deframer.sv
module mrfr_deframer import mrfr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_en,
   input  logic [7:0]      csr_write_data,
   input  byte_item_type   item,
   output deframe_out_type result
);

   logic [7:0]       store_ff [STORE_DEPTH];
   logic [7:0]       store_in [STORE_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       hsum_ff, hsum_in;
   logic [7:0]       dsum_ff, dsum_in;
   logic [7:0]       dev_id_ff;

   logic [IDX_W-1:0] idx;
   logic [CNT_W-1:0] cnt_inc;
   logic [7:0]       b;
   logic [7:0]       len;
   logic [LEN_W-1:0] expected;
   logic [LEN_W-1:0] data_end;
   logic             complete;
   logic             hdr_ok, data_ok, id_ok, is_angle, is_status;
   logic [7:0]       cmd;

   assign b       = item.rx_byte;
   assign idx     = count_ff[IDX_W-1:0];
   assign cnt_inc = count_ff + CNT_W'(1);

   always_comb begin
      store_in = store_ff;
      count_in = count_ff;
      hsum_in  = hsum_ff;
      dsum_in  = dsum_ff;
      complete = 1'b0;
      len      = store_ff[POS_LEN];
      expected = LEN_W'(FRAME_LEN_EMPTY);
      data_end = LEN_W'(POS_DATA) + LEN_W'(store_ff[POS_LEN]);
      if (item.valid) begin
         if (count_ff == '0) begin
            if (b == START_BYTE) begin
               store_in[POS_START] = b;
               count_in = CNT_W'(1);
               hsum_in  = b;
               dsum_in  = '0;
            end
         end else begin
            store_in[idx] = b;
            len = store_in[POS_LEN];
            if (idx < IDX_W'(POS_HSUM)) begin
               hsum_in = hsum_ff + b;
            end else if (idx >= IDX_W'(POS_DATA) && LEN_W'(idx) < data_end) begin
               dsum_in = dsum_ff + b;
            end
            expected = (len == '0) ? LEN_W'(FRAME_LEN_EMPTY)
                                   : LEN_W'(len) + LEN_W'(FRAME_OVERHEAD);
            if (LEN_W'(cnt_inc) == expected) begin
               complete = 1'b1;
               count_in = '0;
            end else if (cnt_inc > CNT_W'(MAX_FRAME_BYTES)) begin
               count_in = '0;
            end else begin
               count_in = cnt_inc;
            end
         end
      end
   end

   // at completion the current byte is the last one, i.e. the data checksum when the length is nonzero
   assign cmd       = store_in[POS_CMD];
   assign hdr_ok    = hsum_in == store_in[POS_HSUM];
   assign data_ok   = (len == '0) || (dsum_in == b);
   assign id_ok     = store_in[POS_ID] == dev_id_ff;
   assign is_angle  = cmd == CMD_ANGLE;
   assign is_status = cmd inside {CMD_STATUS_1, CMD_STATUS_2, CMD_STATUS_3, CMD_STATUS_4};

   always_comb begin
      result.emit = complete && hdr_ok && data_ok && id_ok && (is_angle || is_status);
      result.reply.command_code = cmd;
      result.reply.reply_kind   = is_angle ? KIND_ANGLE : KIND_STATUS;
      result.reply.temperature  = '0;
      result.reply.current_raw  = '0;
      result.reply.speed_raw    = '0;
      result.reply.angle_raw    = '0;
      if (is_angle) begin
         for (int i = 0; i < 8; i++) begin
            result.reply.angle_raw[8*i +: 8] = store_in[POS_DATA + i];
         end
      end else begin
         result.reply.temperature = store_in[POS_DATA];
         result.reply.current_raw = {store_in[POS_DATA + 2], store_in[POS_DATA + 1]};
         result.reply.speed_raw   = {store_in[POS_DATA + 4], store_in[POS_DATA + 3]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            store_ff[i] <= '0;
         end
         count_ff  <= '0;
         hsum_ff   <= '0;
         dsum_ff   <= '0;
         dev_id_ff <= '0;
      end else begin
         store_ff <= store_in;
         count_ff <= count_in;
         hsum_ff  <= hsum_in;
         dsum_ff  <= dsum_in;
         if (csr_write_en) begin
            dev_id_ff <= csr_write_data;
         end
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_FRAME_BYTES))
      else $error("byte count past frame store");

   a_emit_on_step: assert property (@(posedge clock) disable iff (reset)
      result.emit |-> item.valid)
      else $error("reply without a byte transfer");

   a_idle_after_reply: assert property (@(posedge clock) disable iff (reset)
      result.emit |=> count_ff == '0)
      else $error("receiver not idle after reply");

   a_angle_cmd: assert property (@(posedge clock) disable iff (reset)
      (result.emit && result.reply.reply_kind == KIND_ANGLE)
         |-> result.reply.command_code == CMD_ANGLE)
      else $error("angle reply with wrong command");
`endif

endmodule

FILE: src/mrfr_out_stage.sv
module mrfr_out_stage import mrfr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  deframe_out_type result,
   input  logic            rsp_ready,
   output logic            out_free,
   output logic            rsp_valid,
   output reply_type       reply
);

   logic      valid_ff, valid_in;
   reply_type reply_ff, reply_in;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      reply_in = reply_ff;
      if (result.emit) begin
         valid_in = 1'b1;
         reply_in = result.reply;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      reply_ff <= reply_in;
   end

   assign rsp_valid = valid_ff;
   assign reply     = reply_ff;

endmodule

FILE: src/motor_reply_frame_receiver_top.sv
// Reply frame receiver: takes one received byte per transfer on req_ and hunts for the
// 0x3E start byte, then collects command, id, length, header checksum, data and data
// checksum, checking both 8-bit sums as the bytes arrive. A good frame whose id matches
// the device id register (csr_ write) and whose command is known gives one rsp_ transfer:
// an angle reply for 0x92, a status reply for 0x9C/0xA1/0xA2/0xA4. Frames running past
// 21 bytes are dropped. One byte is taken every cycle while req_ready is high; a reply is
// registered in the output register once its last byte leaves the input register, and
// req_ready drops only while a reply waits there and another byte is held in the input register.
module motor_reply_frame_receiver_top import mrfr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_reply_kind,
   output logic [7:0]         rsp_command_code,
   output logic [7:0]         rsp_temperature,
   output logic signed [15:0] rsp_current_raw,
   output logic signed [15:0] rsp_speed_raw,
   output logic signed [63:0] rsp_angle_raw,
   input  logic               csr_write_en,
   input  logic [7:0]         csr_write_data
);

   byte_item_type   item;
   deframe_out_type result;
   reply_type       reply;
   logic            out_free;

   mrfr_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .req_ready   (req_ready),
      .out_free    (out_free),
      .item        (item)
   );

   mrfr_deframer u_deframer (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .item           (item),
      .result         (result)
   );

   mrfr_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .rsp_ready (rsp_ready),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .reply     (reply)
   );

   assign rsp_reply_kind   = reply.reply_kind;
   assign rsp_command_code = reply.command_code;
   assign rsp_temperature  = reply.temperature;
   assign rsp_current_raw  = reply.current_raw;
   assign rsp_speed_raw    = reply.speed_raw;
   assign rsp_angle_raw    = reply.angle_raw;

endmodule
